/* rtl/core/updt_pkg.sv */
// ============================================================================
// updt_pkg
// Shared types and constants for the padded decimal text converter.
// ============================================================================
package updt_pkg;

    // Field widths of the words on both channels
    localparam int VALUE_BITS = 64;
    localparam int MIN_BITS   = 6;
    localparam int CHAR_BITS  = 6;

    // ASCII '0', low six bits
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

    // Shift-and-add-3 correction for a radix of ten
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new input word
        logic conv;   // one binary to BCD step
        logic adv;    // move to the next character position
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic conv_last; // this is the final conversion step
        logic show;      // current position yields a character
        logic last;      // current position is the least significant one
    } t_stat;

endpackage

/* rtl/core/updt_if.sv */
// ============================================================================
// updt_in_if / updt_out_if
// Valid/ready channels for input words and character words.
// ============================================================================
interface updt_in_if
    import updt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [MIN_BITS-1:0]   min_digits;

    modport source (output valid, output value, output min_digits, input ready);
    modport sink   (input valid, input value, input min_digits, output ready);
endinterface

interface updt_out_if
    import updt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/core/updt_datapath.sv */
// ============================================================================
// updt_datapath
// Bit-serial binary to BCD conversion and digit-by-digit character output.
// ============================================================================
module updt_datapath
    import updt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_PAD     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [MIN_BITS-1:0]   i_min_digits,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [CHAR_BITS-1:0]  o_character
);

    // decimal digits needed for the widest value
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCDW  = 4 * NDIG;
    localparam int P0    = ((NDIG > MAX_PAD) ? NDIG : MAX_PAD) - 1;
    localparam int PW    = (P0 > 0) ? $clog2(P0 + 1) : 1;
    localparam int MINW  = $clog2(MAX_PAD + 1);
    localparam int CW    = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CMPW  = ((PW > MINW) ? PW : MINW) + 1;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCDW-1:0]        r_bcd, n_bcd;
    logic [MINW-1:0]        r_min, n_min;
    logic [PW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_seen, n_seen;

    logic [BCDW-1:0]        adj_bcd;
    logic [MIN_BITS:0]      min_ext;
    logic [MIN_BITS:0]      min_sat;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        minr_ext;
    logic                   in_bcd;
    logic [3:0]             cur_digit;

    // add 3 to each digit of 5 or more ahead of the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= DABBLE_LIMIT) begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4] + DABBLE_ADD;
            end else begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // saturate the minimum to MAX_PAD
    always_comb begin
        min_ext = {1'b0, i_min_digits};
        if (32'(min_ext) > MAX_PAD) begin
            min_sat = (MIN_BITS + 1)'(MAX_PAD);
        end else begin
            min_sat = min_ext;
        end
    end

    assign pos_ext   = CMPW'(r_pos);
    assign minr_ext  = CMPW'(r_min);
    assign in_bcd    = (32'(r_pos) < NDIG);
    assign cur_digit = in_bcd ? r_bcd[BCDW-1 -: 4] : 4'd0;

    assign o_stat.conv_last = (r_cnt == '0);
    assign o_stat.last      = (r_pos == '0);
    assign o_stat.show      = r_seen || (pos_ext < minr_ext) || (cur_digit != 4'd0)
                              || (r_pos == '0);
    assign o_character      = ASCII_ZERO + {2'b00, cur_digit};

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_min  = r_min;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_seen = r_seen;
        if (i_cmd.load) begin
            n_bin  = i_value[VALUE_WIDTH-1:0];
            n_bcd  = '0;
            n_min  = MINW'(min_sat);
            n_pos  = PW'(P0);
            n_cnt  = CW'(VALUE_WIDTH - 1);
            n_seen = 1'b0;
        end else if (i_cmd.conv) begin
            {n_bcd, n_bin} = {adj_bcd, r_bin} << 1;
            n_cnt = r_cnt - 1'b1;
        end else if (i_cmd.adv) begin
            if (in_bcd) begin
                n_bcd = r_bcd << 4;
            end
            n_pos = r_pos - 1'b1;
            if (o_stat.show) begin
                n_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_min <= n_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cnt  <= '0;
            r_seen <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
            r_seen <= n_seen;
        end
    end

endmodule

/* rtl/core/updt_ctrl.sv */
// ============================================================================
// updt_ctrl
// Sequencer: accept, convert, then step through the character positions.
// ============================================================================
module updt_ctrl
    import updt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = i_stat.show;
                if (!i_stat.show) begin
                    o_cmd.adv = 1'b1;
                end else if (i_out_ready) begin
                    o_cmd.adv = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/unsigned_to_padded_decimal_text.sv */
// ============================================================================
// unsigned_to_padded_decimal_text
// Unsigned binary word in, zero-padded ASCII decimal characters out.
// ============================================================================
// One input word (value, min_digits) at a time. The low VALUE_WIDTH bits of
// value are converted to BCD by shift-and-add-3, one bit a cycle. The
// characters then leave most significant first, one word per cycle while the
// sink is ready, with leading '0's until at least min_digits characters
// (capped at MAX_PAD) have gone; a zero value with no minimum gives a single
// '0'. last marks the final character. The output walks a position counter
// down from max(MAX_PAD, digit count) - 1 to 0, where the digit count is 20
// for a 64-bit value; suppressed leading positions give no character. The
// next word is taken in the cycle after the last character is accepted.
// Nothing is kept between words.
// ============================================================================
module unsigned_to_padded_decimal_text
    import updt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_PAD     = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    updt_in_if.sink    i_in,
    updt_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    updt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // conversion and character datapath; payload held in registers while stalled
    updt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_PAD     (MAX_PAD)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_min_digits (i_in.min_digits),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_character  (o_out.character)
    );

    assign o_out.last = stat.last;

endmodule
